// ===== hdl/ltrt_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the lottery ticket range table
// no dependencies

package ltrt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int TKT_W = 16;
  localparam int ID_W = 16;

  // command codes
  localparam logic [2:0] CMD_INSERT    = 3'd0;
  localparam logic [2:0] CMD_NEXT_FREE = 3'd1;
  localparam logic [2:0] CMD_FIND      = 3'd2;
  localparam logic [2:0] CMD_GIVE      = 3'd3;
  localparam logic [2:0] CMD_TAKE      = 3'd4;
  localparam logic [2:0] CMD_REMOVE    = 3'd5;

  // response status codes
  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_MISS = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]       command;
    logic [ID_W-1:0]  thread_id;
    logic             is_lottery;
    logic [TKT_W-1:0] first_ticket;
    logic [TKT_W-1:0] last_ticket;
    logic [TKT_W-1:0] drawn_ticket;
    logic [TKT_W-1:0] ticket_count;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  owner_id;
    logic [TKT_W-1:0] next_ticket;
  } rsp_t;

  typedef struct packed {
    logic             lottery;
    logic [ID_W-1:0]  id;
    logic [TKT_W-1:0] first;
    logic [TKT_W-1:0] last;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic             set_valid;
    logic             clr_valid;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic   valid;
    entry_t data;
  } tbl_rd_t;

  // context handed from the sequencer to the entry evaluation unit
  typedef struct packed {
    logic             shift_phase;
    logic [2:0]       cmd;
    logic [ID_W-1:0]  thread_id;
    logic [TKT_W-1:0] drawn;
    logic [TKT_W-1:0] top;
    logic [IDX_W-1:0] tgt;
    logic [TKT_W-1:0] edge_tk;
    logic [TKT_W-1:0] delta;
    logic             up;
    logic             shift_en;
    logic [TKT_W-1:0] new_last;
  } ctx_t;

  typedef struct packed {
    logic   hit;
    logic   upd;
    logic   kill;
    entry_t data;
  } eval_t;

endpackage

// ===== hdl/ltrt_table.sv =====
`timescale 1ns / 1ps
// entry storage: memory of entry records with registered read, valid bits in flops
// depends on ltrt_pkg

module ltrt_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ltrt_pkg::IDX_W-1:0] rd_addr,
  input  ltrt_pkg::tbl_wr_t          wr,
  output ltrt_pkg::tbl_rd_t          rd
);

  ltrt_pkg::entry_t                      mem [ltrt_pkg::TABLE_ENTRIES];
  logic [ltrt_pkg::TABLE_ENTRIES-1:0]    valid;
  ltrt_pkg::entry_t                      rd_data;
  logic                                  rd_valid;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.set_valid) begin
        valid[wr.addr] <= 1'b1;
      end else if (wr.clr_valid) begin
        valid[wr.addr] <= 1'b0;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd.valid = rd_valid;
  assign rd.data  = rd_data;

endmodule

// ===== hdl/ltrt_unit.sv =====
`timescale 1ns / 1ps
// shared entry evaluation unit: match compares in the scan pass; target update or
// removal, and range shift add/subtract of lottery ranges above it, in the shift pass
// depends on ltrt_pkg

module ltrt_unit (
  input  ltrt_pkg::ctx_t             ctx,
  input  ltrt_pkg::tbl_rd_t          rd,
  input  logic [ltrt_pkg::IDX_W-1:0] idx,
  output ltrt_pkg::eval_t            ev
);

  always_comb begin
    ev      = '0;
    ev.data = rd.data;
    if (!ctx.shift_phase) begin
      case (ctx.cmd) inside
        ltrt_pkg::CMD_INSERT: begin
          ev.hit = !rd.valid;
        end
        ltrt_pkg::CMD_NEXT_FREE: begin
          ev.hit = rd.valid && rd.data.lottery && (rd.data.last > ctx.top);
        end
        ltrt_pkg::CMD_FIND: begin
          ev.hit = rd.valid && rd.data.lottery &&
                   (rd.data.first <= ctx.drawn) && (rd.data.last >= ctx.drawn);
        end
        ltrt_pkg::CMD_GIVE, ltrt_pkg::CMD_TAKE, ltrt_pkg::CMD_REMOVE: begin
          ev.hit = rd.valid && (rd.data.id == ctx.thread_id);
        end
        default: begin
          ev.hit = 1'b0;
        end
      endcase
    end else if (idx == ctx.tgt) begin
      if (ctx.cmd == ltrt_pkg::CMD_REMOVE) begin
        ev.kill = 1'b1;
      end else begin
        ev.upd          = 1'b1;
        ev.data.last    = ctx.new_last;
      end
    end else if (ctx.shift_en && rd.valid && rd.data.lottery &&
                 (rd.data.first > ctx.edge_tk)) begin
      // lottery range above the target moves with it
      ev.upd = 1'b1;
      if (ctx.up) begin
        ev.data.first = rd.data.first + ctx.delta;
        ev.data.last  = rd.data.last + ctx.delta;
      end else begin
        ev.data.first = rd.data.first - ctx.delta;
        ev.data.last  = rd.data.last - ctx.delta;
      end
    end
  end

endmodule

// ===== hdl/ltrt_ctrl.sv =====
`timescale 1ns / 1ps
// command sequencer: scan pass over the table, target prep, shift pass, result
// depends on ltrt_pkg; drives ltrt_table and ltrt_unit

module ltrt_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  ltrt_pkg::req_t             req,
  output logic                       req_stall,
  input  logic                       rsp_free,
  output logic                       res_valid,
  output ltrt_pkg::rsp_t             res,
  output logic [ltrt_pkg::IDX_W-1:0] rd_addr,
  output logic [ltrt_pkg::IDX_W-1:0] d_idx,
  output ltrt_pkg::tbl_wr_t          wr,
  output ltrt_pkg::ctx_t             ctx,
  input  ltrt_pkg::eval_t            ev
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t                         state;
  ltrt_pkg::req_t                 req_q;
  logic [ltrt_pkg::CNT_W-1:0]     rd_cnt;
  logic                           d_vld;
  logic                           found;
  logic [ltrt_pkg::IDX_W-1:0]     tgt;
  logic [ltrt_pkg::TKT_W-1:0]     t_first;
  logic [ltrt_pkg::TKT_W-1:0]     t_last;
  logic                           t_lot;
  logic [ltrt_pkg::TKT_W-1:0]     top;
  logic [ltrt_pkg::ID_W-1:0]      owner;
  logic [ltrt_pkg::TKT_W-1:0]     edge_tk;
  logic [ltrt_pkg::TKT_W-1:0]     delta;
  logic                           up;
  logic                           shift_en;
  logic [ltrt_pkg::TKT_W-1:0]     new_last;

  logic                           rd_en;
  logic                           last_idx;
  logic                           is_tgt_cmd;
  logic [ltrt_pkg::TKT_W-1:0]     span;

  assign rd_en = ((state == S_SCAN) || (state == S_SHIFT)) &&
                 (rd_cnt < ltrt_pkg::CNT_W'(ltrt_pkg::TABLE_ENTRIES));
  assign rd_addr  = rd_en ? rd_cnt[ltrt_pkg::IDX_W-1:0] : '0;
  assign last_idx = d_vld && (d_idx == ltrt_pkg::IDX_W'(ltrt_pkg::TABLE_ENTRIES - 1));
  assign is_tgt_cmd = (req_q.command == ltrt_pkg::CMD_GIVE) ||
                      (req_q.command == ltrt_pkg::CMD_TAKE) ||
                      (req_q.command == ltrt_pkg::CMD_REMOVE);
  assign span = (t_last >= t_first) ? (t_last - t_first) : '0;

  assign req_stall = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    ctx.shift_phase = (state == S_SHIFT);
    ctx.cmd         = req_q.command;
    ctx.thread_id   = req_q.thread_id;
    ctx.drawn       = req_q.drawn_ticket;
    ctx.top         = top;
    ctx.tgt         = tgt;
    ctx.edge_tk     = edge_tk;
    ctx.delta       = delta;
    ctx.up          = up;
    ctx.shift_en    = shift_en;
    ctx.new_last    = new_last;
  end

  always_comb begin
    wr      = '0;
    wr.addr = d_idx;
    wr.data = ev.data;
    if ((state == S_SCAN) && d_vld && ev.hit && !found &&
        (req_q.command == ltrt_pkg::CMD_INSERT)) begin
      wr.we           = 1'b1;
      wr.set_valid    = 1'b1;
      wr.data.lottery = req_q.is_lottery;
      wr.data.id      = req_q.thread_id;
      wr.data.first   = req_q.first_ticket;
      wr.data.last    = req_q.last_ticket;
    end else if ((state == S_SHIFT) && d_vld) begin
      wr.we        = ev.upd;
      wr.clr_valid = ev.kill;
    end
  end

  always_comb begin
    res = '0;
    case (req_q.command) inside
      ltrt_pkg::CMD_INSERT: begin
        res.status = found ? ltrt_pkg::STS_OK : ltrt_pkg::STS_FULL;
      end
      ltrt_pkg::CMD_NEXT_FREE: begin
        res.status      = ltrt_pkg::STS_OK;
        res.next_ticket = top + 1'b1;
      end
      ltrt_pkg::CMD_FIND: begin
        res.status   = found ? ltrt_pkg::STS_OK : ltrt_pkg::STS_MISS;
        res.owner_id = owner;
      end
      ltrt_pkg::CMD_GIVE, ltrt_pkg::CMD_TAKE, ltrt_pkg::CMD_REMOVE: begin
        res.status = found ? ltrt_pkg::STS_OK : ltrt_pkg::STS_MISS;
      end
      default: begin
        res.status = ltrt_pkg::STS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      d_vld <= 1'b0;
      found <= 1'b0;
    end else begin
      d_vld <= rd_en;
      d_idx <= rd_addr;
      if (rd_en) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q  <= req;
            rd_cnt <= '0;
            found  <= 1'b0;
            top    <= '0;
            owner  <= '0;
            if (req.command > ltrt_pkg::CMD_REMOVE) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (d_vld && ev.hit) begin
            if (req_q.command == ltrt_pkg::CMD_NEXT_FREE) begin
              top <= ev.data.last;
            end else if (!found) begin
              // first match wins
              found   <= 1'b1;
              tgt     <= d_idx;
              owner   <= ev.data.id;
              t_first <= ev.data.first;
              t_last  <= ev.data.last;
              t_lot   <= ev.data.lottery;
            end
          end
          if (last_idx) begin
            if (is_tgt_cmd && (found || ev.hit)) begin
              state <= S_PREP;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_PREP: begin
          rd_cnt  <= '0;
          edge_tk <= t_last;
          case (req_q.command) inside
            ltrt_pkg::CMD_GIVE: begin
              delta    <= req_q.ticket_count;
              up       <= 1'b1;
              shift_en <= 1'b1;
              new_last <= t_last + req_q.ticket_count;
            end
            ltrt_pkg::CMD_TAKE: begin
              up       <= 1'b0;
              shift_en <= 1'b1;
              // clamp the count to the range span
              if (req_q.ticket_count > span) begin
                delta    <= span;
                new_last <= t_first;
              end else begin
                delta    <= req_q.ticket_count;
                new_last <= t_last - req_q.ticket_count;
              end
            end
            default: begin
              delta    <= t_last - t_first + 1'b1;
              up       <= 1'b0;
              shift_en <= t_lot;
              new_last <= t_last;
            end
          endcase
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          if (last_idx) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted but sequencer not busy");

  a_shift_needs_target: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> found)
    else $error("shift pass without a target entry");

  a_clear_only_remove: assert property (@(posedge clk) disable iff (rst)
    wr.clr_valid |-> ((state == S_SHIFT) && (req_q.command == ltrt_pkg::CMD_REMOVE)))
    else $error("entry cleared outside a remove");

  a_set_only_insert: assert property (@(posedge clk) disable iff (rst)
    wr.set_valid |-> ((state == S_SCAN) && (req_q.command == ltrt_pkg::CMD_INSERT) && !found))
    else $error("entry set outside the first free slot of an insert");

  a_data_in_pass: assert property (@(posedge clk) disable iff (rst)
    d_vld |-> ((state == S_SCAN) || (state == S_SHIFT)))
    else $error("table read data outside a pass");

endmodule

// ===== hdl/lottery_ticket_range_table.sv =====
`timescale 1ns / 1ps
// insert, next free, find and commands on unknown threads respond after one scan pass
// over the table; give, take and remove of a known thread add a target prep step and
// a shift pass, with one table read port swept per pass. reserved codes skip the scan.
// throughput: one request at a time, next request taken once the result is handed
// to the response register. synchronous reset clears all valid bits and the sequencer.
// depends on ltrt_pkg, ltrt_table, ltrt_unit, ltrt_ctrl

module lottery_ticket_range_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  ltrt_pkg::req_t req,
  output logic           req_stall,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ltrt_pkg::rsp_t rsp
);

  logic [ltrt_pkg::IDX_W-1:0] rd_addr;
  logic [ltrt_pkg::IDX_W-1:0] d_idx;
  ltrt_pkg::tbl_wr_t          wr;
  ltrt_pkg::tbl_rd_t          rd;
  ltrt_pkg::ctx_t             ctx;
  ltrt_pkg::eval_t            ev;
  logic                       res_valid;
  ltrt_pkg::rsp_t             res;
  logic                       rsp_free;

  assign rsp_free = !rsp_valid || !rsp_stall;

  ltrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .rsp_free  (rsp_free),
    .res_valid (res_valid),
    .res       (res),
    .rd_addr   (rd_addr),
    .d_idx     (d_idx),
    .wr        (wr),
    .ctx       (ctx),
    .ev        (ev)
  );

  ltrt_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  ltrt_unit u_unit (
    .ctx (ctx),
    .rd  (rd),
    .idx (d_idx),
    .ev  (ev)
  );

  // response register parts the sequencer from the downstream stall
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && rsp_free) begin
      rsp <= res;
    end
  end

endmodule

// ===== test/lottery_ticket_range_table_tb.sv =====
`timescale 1ns / 1ps
// testbench for lottery_ticket_range_table: directed and random command streams
// checked against a behavioral ticket table kept inside the bench
// depends on ltrt_pkg and the lottery_ticket_range_table rtl

module lottery_ticket_range_table_tb;

  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam int RANDOM_REQS = 830;
  localparam int PHASE_LEN   = 120;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  ltrt_pkg::req_t req = '0;
  logic req_stall;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  ltrt_pkg::rsp_t rsp;

  lottery_ticket_range_table dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req      (req),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bench copy of the thread table
  logic        tbl_valid [ltrt_pkg::TABLE_ENTRIES];
  logic        tbl_lot   [ltrt_pkg::TABLE_ENTRIES];
  logic [15:0] tbl_id    [ltrt_pkg::TABLE_ENTRIES];
  logic [15:0] tbl_first [ltrt_pkg::TABLE_ENTRIES];
  logic [15:0] tbl_last  [ltrt_pkg::TABLE_ENTRIES];

  ltrt_pkg::req_t req_backlog[$];
  ltrt_pkg::rsp_t due_rsp[$];

  int reqs_made = 0;
  int reqs_taken = 0;
  int rsps_checked = 0;
  int mismatches = 0;
  int full_seen = 0;
  int miss_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;

  function automatic logic [15:0] lottery_top();
    logic [15:0] top;
    top = '0;
    for (int i = 0; i < ltrt_pkg::TABLE_ENTRIES; i++)
      if (tbl_valid[i] && tbl_lot[i] && tbl_last[i] > top) top = tbl_last[i];
    return top;
  endfunction

  function automatic int find_thread(logic [15:0] id);
    for (int i = 0; i < ltrt_pkg::TABLE_ENTRIES; i++)
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  // move lottery ranges starting above a ticket, target excluded
  function automatic void shift_lottery(int skip_idx, logic [15:0] above,
                                        logic [15:0] amount, bit grow);
    for (int i = 0; i < ltrt_pkg::TABLE_ENTRIES; i++) begin
      if (i != skip_idx && tbl_valid[i] && tbl_lot[i] && tbl_first[i] > above) begin
        if (grow) begin
          tbl_first[i] = tbl_first[i] + amount;
          tbl_last[i]  = tbl_last[i] + amount;
        end else begin
          tbl_first[i] = tbl_first[i] - amount;
          tbl_last[i]  = tbl_last[i] - amount;
        end
      end
    end
  endfunction

  function automatic ltrt_pkg::rsp_t run_ticket_cmd(ltrt_pkg::req_t r);
    ltrt_pkg::rsp_t o;
    int             t;
    logic [15:0]    old;
    logic [15:0]    cnt;
    logic [15:0]    span;
    o = '0;
    t = find_thread(r.thread_id);
    cnt = r.ticket_count;
    case (r.command)
      ltrt_pkg::CMD_INSERT: begin
        o.status = ltrt_pkg::STS_FULL;
        for (int i = 0; i < ltrt_pkg::TABLE_ENTRIES; i++) begin
          if (!tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_lot[i]   = r.is_lottery;
            tbl_id[i]    = r.thread_id;
            tbl_first[i] = r.first_ticket;
            tbl_last[i]  = r.last_ticket;
            o.status = ltrt_pkg::STS_OK;
            break;
          end
        end
      end
      ltrt_pkg::CMD_NEXT_FREE: o.next_ticket = lottery_top() + 16'd1;
      ltrt_pkg::CMD_FIND: begin
        o.status = ltrt_pkg::STS_MISS;
        for (int i = 0; i < ltrt_pkg::TABLE_ENTRIES; i++) begin
          if (tbl_valid[i] && tbl_lot[i] && tbl_first[i] <= r.drawn_ticket &&
              tbl_last[i] >= r.drawn_ticket) begin
            o.owner_id = tbl_id[i];
            o.status = ltrt_pkg::STS_OK;
            break;
          end
        end
      end
      ltrt_pkg::CMD_GIVE, ltrt_pkg::CMD_TAKE, ltrt_pkg::CMD_REMOVE: begin
        if (t < 0) begin
          o.status = ltrt_pkg::STS_MISS;
        end else if (r.command == ltrt_pkg::CMD_GIVE) begin
          old = tbl_last[t];
          tbl_last[t] = old + cnt;
          shift_lottery(t, old, cnt, 1'b1);
        end else if (r.command == ltrt_pkg::CMD_TAKE) begin
          old = tbl_last[t];
          span = (old >= tbl_first[t]) ? old - tbl_first[t] : 16'd0;
          if (cnt > span) begin
            cnt = span;
            tbl_last[t] = tbl_first[t];
          end else begin
            tbl_last[t] = old - cnt;
          end
          shift_lottery(t, old, cnt, 1'b0);
        end else begin
          tbl_valid[t] = 1'b0;
          // lottery removal closes the hole it leaves
          if (tbl_lot[t])
            shift_lottery(t, tbl_last[t], tbl_last[t] - tbl_first[t] + 16'd1, 1'b0);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic int pick_live(bit lot_only);
    int hits[$];
    for (int i = 0; i < ltrt_pkg::TABLE_ENTRIES; i++)
      if (tbl_valid[i] && (tbl_lot[i] || !lot_only)) hits.push_back(i);
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(hits.size() - 1)];
  endfunction

  function automatic ltrt_pkg::req_t mk_req(logic [2:0] cmd, logic [15:0] id, logic lot,
                                            logic [15:0] first, logic [15:0] last,
                                            logic [15:0] drawn, logic [15:0] cnt);
    ltrt_pkg::req_t r;
    r.command      = cmd;
    r.thread_id    = id;
    r.is_lottery   = lot;
    r.first_ticket = first;
    r.last_ticket  = last;
    r.drawn_ticket = drawn;
    r.ticket_count = cnt;
    return r;
  endfunction

  task automatic add_req(ltrt_pkg::req_t r);
    while (req_backlog.size() >= 2) @(posedge clk);
    req_backlog.push_back(r);
    reqs_made++;
  endtask

  // request driver; the expected response is worked out when a request is taken
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) begin
        due_rsp.push_back(run_ticket_cmd(req));
        reqs_taken++;
      end
      if (req_backlog.size() > 0 &&
          ((reqs_taken >= 400 && reqs_taken < 550) || $urandom_range(99) >= 8)) begin
        req <= req_backlog.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response monitor and receiver stall
  always @(posedge clk) begin
    ltrt_pkg::rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp.size() == 0) begin
          $display("%0t: response with nothing outstanding: status %0d owner %h next %h",
                   $time, rsp.status, rsp.owner_id, rsp.next_ticket);
          mismatches++;
        end else begin
          want = due_rsp.pop_front();
          rsps_checked++;
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            mismatches++;
          end
          if (rsp.owner_id !== want.owner_id) begin
            $display("%0t: owner_id expected %h actual %h", $time, want.owner_id,
                     rsp.owner_id);
            mismatches++;
          end
          if (rsp.next_ticket !== want.next_ticket) begin
            $display("%0t: next_ticket expected %h actual %h", $time, want.next_ticket,
                     rsp.next_ticket);
            mismatches++;
          end
          if (want.status == ltrt_pkg::STS_FULL) full_seen++;
          if (want.status == ltrt_pkg::STS_MISS) miss_seen++;
        end
      end
      // one long back-pressure stretch so the block has to stall requests
      if (rsps_checked == 120 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) hold_left--;
      rsp_stall <= (hold_left > 0) ||
                   (!(rsps_checked >= 400 && rsps_checked < 550) && $urandom_range(99) < 8);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no request or response moved for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    ltrt_pkg::req_t r;
    logic [95:0]    raw;
    int             w;
    int             k;
    bit             fill;
    for (int i = 0; i < ltrt_pkg::TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_lot[i]   = 1'b0;
      tbl_id[i]    = '0;
      tbl_first[i] = '0;
      tbl_last[i]  = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty table, unknown threads
    add_req(mk_req(ltrt_pkg::CMD_NEXT_FREE, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000));
    add_req(mk_req(ltrt_pkg::CMD_FIND,      16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000));
    add_req(mk_req(ltrt_pkg::CMD_GIVE,      16'hffff, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                   16'hffff));
    add_req(mk_req(ltrt_pkg::CMD_TAKE,      16'hffff, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                   16'h0001));
    add_req(mk_req(ltrt_pkg::CMD_REMOVE,    16'hffff, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000));
    // two lottery threads and a round-robin one spanning every ticket
    add_req(mk_req(ltrt_pkg::CMD_INSERT,    16'hffff, 1'b1, 16'h0001, 16'h000a, 16'h0000,
                   16'h0000));
    add_req(mk_req(ltrt_pkg::CMD_INSERT,    16'h0000, 1'b1, 16'h000b, 16'h0014, 16'h0000,
                   16'h0000));
    add_req(mk_req(ltrt_pkg::CMD_INSERT,    16'h1234, 1'b0, 16'h0000, 16'hffff, 16'h0000,
                   16'h0000));
    add_req(mk_req(ltrt_pkg::CMD_NEXT_FREE, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000));
    add_req(mk_req(ltrt_pkg::CMD_FIND,      16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000));
    add_req(mk_req(ltrt_pkg::CMD_FIND,      16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0001,
                   16'h0000));
    add_req(mk_req(ltrt_pkg::CMD_FIND,      16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0014,
                   16'h0000));
    add_req(mk_req(ltrt_pkg::CMD_FIND,      16'h0000, 1'b0, 16'h0000, 16'h0000, 16'hffff,
                   16'h0000));
    add_req(mk_req(ltrt_pkg::CMD_GIVE,      16'hffff, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                   16'h0005));
    // round-robin give wraps its last ticket
    add_req(mk_req(ltrt_pkg::CMD_GIVE,      16'h1234, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                   16'h0003));
    add_req(mk_req(ltrt_pkg::CMD_TAKE,      16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                   16'hffff));
    add_req(mk_req(ltrt_pkg::CMD_TAKE,      16'hffff, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                   16'h0002));
    add_req(mk_req(ltrt_pkg::CMD_REMOVE,    16'hffff, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000));
    add_req(mk_req(ltrt_pkg::CMD_REMOVE,    16'h1234, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000));
    // inverted range: take has nothing to remove
    add_req(mk_req(ltrt_pkg::CMD_INSERT,    16'h0007, 1'b1, 16'h0064, 16'h0032, 16'h0000,
                   16'h0000));
    add_req(mk_req(ltrt_pkg::CMD_TAKE,      16'h0007, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                   16'h0001));
    // range at the top so next free wraps to zero
    add_req(mk_req(ltrt_pkg::CMD_INSERT,    16'h0008, 1'b1, 16'hfff0, 16'hffff, 16'h0000,
                   16'h0000));
    add_req(mk_req(ltrt_pkg::CMD_NEXT_FREE, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000,
                   16'h0000));
    add_req(mk_req(CMD_RSVD6,     16'hffff, 1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    add_req(mk_req(CMD_RSVD7,     16'hffff, 1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff));

    // random part alternates between filling and draining the table
    for (int n = 0; n < RANDOM_REQS; n++) begin
      fill = ((n / PHASE_LEN) % 2) == 0;
      raw = {$urandom, $urandom, $urandom};
      r = raw[$bits(ltrt_pkg::req_t)-1:0];
      w = $urandom_range(99);
      if (w < 45 && (fill || w < 15)) r.command = ltrt_pkg::CMD_INSERT;
      else if (w < 45 || (w >= 90 && w < 96)) r.command = ltrt_pkg::CMD_REMOVE;
      else if (w < 55) r.command = ltrt_pkg::CMD_NEXT_FREE;
      else if (w < 70) r.command = ltrt_pkg::CMD_FIND;
      else if (w < 80) r.command = ltrt_pkg::CMD_GIVE;
      else if (w < 90) r.command = ltrt_pkg::CMD_TAKE;
      else if (w < 98) r.command = $urandom_range(1) ? CMD_RSVD6 : CMD_RSVD7;
      case (r.command)
        ltrt_pkg::CMD_INSERT: begin
          if ($urandom_range(9) < 8) r.thread_id = 16'($urandom_range(24));
          if ($urandom_range(9) < 9) begin
            r.first_ticket = lottery_top() + 16'd1;
            r.last_ticket = r.first_ticket + 16'($urandom_range(40));
          end
          r.is_lottery = $urandom_range(3) != 0;
        end
        ltrt_pkg::CMD_FIND: begin
          k = pick_live(1'b1);
          if (k >= 0 && $urandom_range(9) < 8 && tbl_first[k] <= tbl_last[k])
            r.drawn_ticket = tbl_first[k] +
                             16'($urandom_range(tbl_last[k] - tbl_first[k]));
        end
        ltrt_pkg::CMD_GIVE, ltrt_pkg::CMD_TAKE, ltrt_pkg::CMD_REMOVE: begin
          k = pick_live(1'b0);
          if (k >= 0 && $urandom_range(9) < 8) r.thread_id = tbl_id[k];
          else if ($urandom_range(1)) r.thread_id = 16'($urandom_range(24));
          if ($urandom_range(9) < 9) r.ticket_count = 16'($urandom_range(24));
        end
        default: ;
      endcase
      add_req(r);
    end

    while (reqs_taken < reqs_made || due_rsp.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("%0d requests issued, %0d responses compared (%0d table full, %0d no match)",
             reqs_made, rsps_checked, full_seen, miss_seen);
    $display("mix of fill and drain phases with random idling and a long response hold");
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ltrt_pkg.sv
hdl/ltrt_table.sv
hdl/ltrt_unit.sv
hdl/ltrt_ctrl.sv
hdl/lottery_ticket_range_table.sv
test/lottery_ticket_range_table_tb.sv
